// ===== hw/rtl/ple_pkg.sv =====
`default_nettype none
package ple_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_INS_AT    = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_BACK  = 3'd4,
        MODE_DEL_AT    = 3'd5,
        MODE_DUMP      = 3'd6
    } ple_mode_t;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BADPOS = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } ple_state_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] value;
        logic [7:0]         position;
    } ple_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [CNT_W-1:0]   count;
        logic signed [31:0] element;
        logic               last;
    } ple_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic edit;
        logic dump_begin;
        logic dump_step;
    } ple_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic at_last;
    } ple_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/positional_list_engine_unit.sv =====
`default_nettype none
// Ordered list of up to DEPTH (16) signed 32-bit values held in a row of shifting
// cells. A request is taken when start is high and busy is low. Every insert or
// delete, and a dump of an empty list, is done in the cycle it is taken and its
// single result word appears on result with result_valid high in the next cycle;
// such requests can be issued every cycle. A dump of a non-empty list raises busy
// and streams one element per cycle, front first, the final word marked by last;
// the dump ends when the dump index counter reaches the last stored element.
// The receiver cannot stall: each word is present for exactly one cycle.
module positional_list_engine_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ple_pkg::ple_req_t req,
    output logic                   result_valid,
    output ple_pkg::ple_rsp_t      result
);
    import ple_pkg::*;

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (req.mode),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    ple_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    // a dump in progress emits a word every cycle
    a_dump_streams: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_valid)
        else $error("dump cycle without result word");

    // only dump words can be unmarked, and only while the dump still runs
    a_unmarked_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("unmarked word outside a dump");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.count <= CNT_W'(DEPTH)))
        else $error("count beyond depth");

    // a dump ends on its marked word
    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && result.last))
        else $error("dump ended without final word");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ple_ctrl.sv =====
`default_nettype none
module ple_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        mode,
    input  wire ple_pkg::ple_stat_t stat,
    output logic                   busy,
    output ple_pkg::ple_cmd_t      cmd
);
    import ple_pkg::*;

    ple_state_t state_reg;
    ple_state_t state_next;
    logic       take;
    logic       is_dump;

    assign take    = start && (state_reg == ST_IDLE);
    assign is_dump = (mode == MODE_DUMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && is_dump && !stat.empty)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (stat.at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy           = 1'b0;
        cmd.edit       = 1'b0;
        cmd.dump_begin = 1'b0;
        cmd.dump_step  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // empty-list dump answers like an edit: one word, no walk
                cmd.edit       = take && ((mode inside {MODE_INS_FRONT, MODE_INS_BACK,
                                 MODE_INS_AT, MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT})
                                 || (is_dump && stat.empty));
                cmd.dump_begin = take && is_dump && !stat.empty;
            end
            ST_DUMP:
            begin
                busy          = 1'b1;
                cmd.dump_step = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ple_dp.sv =====
`default_nettype none
module ple_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ple_pkg::ple_req_t req,
    input  wire ple_pkg::ple_cmd_t cmd,
    output ple_pkg::ple_stat_t     stat,
    output logic                   result_valid,
    output ple_pkg::ple_rsp_t      result
);
    import ple_pkg::*;

    logic signed [31:0] cell_reg [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   dump_idx_reg;
    logic               result_valid_reg;
    ple_rsp_t           result_reg;

    logic [1:0]         edit_status;
    logic               do_ins;
    logic               do_del;
    logic [IDX_W-1:0]   edit_idx;
    logic [8:0]         pos_ext;
    logic [8:0]         cnt_ext;
    logic               full;
    logic               empty;

    assign pos_ext = {1'b0, req.position};
    assign cnt_ext = 9'(count_reg);
    assign full    = (count_reg >= CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    always_comb
    begin
        edit_status = STAT_OK;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        edit_idx    = '0;
        count_next  = count_reg;
        case (req.mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT:
            begin
                if (req.mode == MODE_INS_AT &&
                    (req.position == 8'd0 || pos_ext > cnt_ext + 9'd1))
                begin
                    edit_status = STAT_BADPOS;
                end
                else if (full)
                begin
                    edit_status = STAT_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                if (req.mode == MODE_INS_BACK)
                begin
                    edit_idx = count_reg[IDX_W-1:0];
                end
                else if (req.mode == MODE_INS_AT)
                begin
                    edit_idx = IDX_W'(req.position - 8'd1);
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT:
            begin
                if (empty)
                begin
                    edit_status = STAT_EMPTY;
                end
                else if (req.mode == MODE_DEL_AT &&
                         (req.position == 8'd0 || pos_ext > cnt_ext))
                begin
                    edit_status = STAT_BADPOS;
                end
                else
                begin
                    do_del     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                if (req.mode == MODE_DEL_BACK)
                begin
                    edit_idx = IDX_W'(count_reg - CNT_W'(1));
                end
                else if (req.mode == MODE_DEL_AT)
                begin
                    edit_idx = IDX_W'(req.position - 8'd1);
                end
            end
            MODE_DUMP:
            begin
                edit_status = STAT_EMPTY;
            end
            default:
            begin
                edit_status = STAT_OK;
            end
        endcase
    end

    // cells shift as a row: up on insert, down on delete
    always_ff @(posedge clk)
    begin
        if (cmd.edit && do_ins)
        begin
            for (int i = 1; i < DEPTH; i++)
            begin
                if (i == int'(edit_idx))
                begin
                    cell_reg[i] <= req.value;
                end
                else if (i > int'(edit_idx))
                begin
                    cell_reg[i] <= cell_reg[i-1];
                end
            end
            if (edit_idx == '0)
            begin
                cell_reg[0] <= req.value;
            end
        end
        else if (cmd.edit && do_del)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (i >= int'(edit_idx))
                begin
                    cell_reg[i] <= cell_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            dump_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.edit || cmd.dump_step;
            if (cmd.edit)
            begin
                count_reg <= count_next;
            end
            if (cmd.dump_begin)
            begin
                dump_idx_reg <= '0;
            end
            else if (cmd.dump_step)
            begin
                dump_idx_reg <= dump_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edit)
        begin
            result_reg.status  <= edit_status;
            result_reg.count   <= count_next;
            result_reg.element <= '0;
            result_reg.last    <= 1'b1;
        end
        else if (cmd.dump_step)
        begin
            result_reg.status  <= STAT_OK;
            result_reg.count   <= count_reg;
            result_reg.element <= cell_reg[dump_idx_reg];
            result_reg.last    <= stat.at_last;
        end
    end

    assign stat.empty   = empty;
    assign stat.at_last = (CNT_W'(dump_idx_reg) == count_reg - CNT_W'(1));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire
